// ===== design/bbcd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcd_pkg
// Shared constants, register indexes and interface types of the black border
// crop detector.
// ----------------------------------------------------------------------------
package bbcd_pkg;

	// default frame size limits, handed to the top level as parameter defaults
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// configuration port
	localparam int CFG_W   = 12;
	localparam int IDX_W   = 2;
	localparam int SIZE_W  = 12;
	localparam int LIMIT_W = 8;
	localparam int ROUND_W = 11;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_BLACK_LIMIT   = 2'd2;
	localparam logic [IDX_W-1:0] REG_SIZE_ROUNDING = 2'd3;

	localparam int                 RST_FRAME_WIDTH   = 720;
	localparam int                 RST_FRAME_HEIGHT  = 576;
	localparam logic [LIMIT_W-1:0] RST_BLACK_LIMIT   = 8'd24;
	localparam logic [ROUND_W-1:0] RST_SIZE_ROUNDING = 11'd0;

	// payload widths
	localparam int PIX_W   = 8;
	localparam int BOUND_W = 11;
	localparam int ORG_W   = 14;
	localparam int DIM_W   = 13;

	// crop arithmetic: coordinates stay below 4096, sizes within +-4096
	localparam int CALC_W = 16;
	localparam int DVD_W  = 13;
	localparam int DVS_W  = 12;

	localparam logic [DVS_W-1:0] DEF_ROUNDING = 12'd16;

	typedef logic signed [CALC_W-1:0] calc_t;

	// frame-end request from the pixel pipeline to the crop unit
	typedef struct packed {
		logic               start;
		logic [SIZE_W-1:0]  left;
		logic [SIZE_W-1:0]  right;
		logic [SIZE_W-1:0]  top;
		logic [SIZE_W-1:0]  bottom;
		logic [ROUND_W-1:0] rounding;
	} crop_req_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== design/bbcd_div.sv =====
// ----------------------------------------------------------------------------
// bbcd_div
// Restoring remainder unit: one dividend bit per cycle, remainder valid with
// the done pulse.
// ----------------------------------------------------------------------------
module bbcd_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bbcd_pkg::div_req_t  req,
	output bbcd_pkg::div_rsp_t  rsp
);

	localparam int NW = bbcd_pkg::DVD_W;
	localparam int DW = bbcd_pkg::DVS_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    dvd_q;
	logic [DW-1:0]    dvs_q;
	logic [DW-1:0]    rem_q;
	logic [DW:0]      trial;
	logic             fits;

	// shift in the next dividend bit and try a subtract
	assign trial = {rem_q, dvd_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== design/bbcd_crop.sv =====
// ----------------------------------------------------------------------------
// bbcd_crop
// Per-frame crop rectangle: even-rounded origin, size trimmed to the rounding
// multiple with truncating remainder, result held in the output register.
// ----------------------------------------------------------------------------
module bbcd_crop (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bbcd_pkg::crop_req_t                   req,
	output logic                                  idle,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [bbcd_pkg::BOUND_W-1:0]   left_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   right_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   top_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   bottom_bound,
	output logic signed [bbcd_pkg::ORG_W-1:0]     crop_x,
	output logic signed [bbcd_pkg::ORG_W-1:0]     crop_y,
	output logic signed [bbcd_pkg::DIM_W-1:0]     crop_w,
	output logic signed [bbcd_pkg::DIM_W-1:0]     crop_h
);

	localparam int BW  = bbcd_pkg::BOUND_W;
	localparam int OW  = bbcd_pkg::ORG_W;
	localparam int MW  = bbcd_pkg::DIM_W;
	localparam int SZW = bbcd_pkg::SIZE_W;
	localparam int NW  = bbcd_pkg::DVD_W;
	localparam int DW  = bbcd_pkg::DVS_W;
	localparam int RW  = bbcd_pkg::ROUND_W;
	localparam int KW  = bbcd_pkg::CALC_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_DIV_W  = 3'd2;
	localparam logic [2:0] ST_WAIT_W = 3'd3;
	localparam logic [2:0] ST_DIV_H  = 3'd4;
	localparam logic [2:0] ST_WAIT_H = 3'd5;
	localparam logic [2:0] ST_HOLD   = 3'd6;

	// round down to even in two's complement
	function automatic bbcd_pkg::calc_t floor_even(bbcd_pkg::calc_t v);
		return v & ~bbcd_pkg::calc_t'(1);
	endfunction

	// origin shift for a trimmed remainder: floor_even(trunc(s / 2) + 1)
	function automatic bbcd_pkg::calc_t center_adj(bbcd_pkg::calc_t s);
		bbcd_pkg::calc_t half;
		half = (s + bbcd_pkg::calc_t'(s[KW-1])) >>> 1;
		return floor_even(half + bbcd_pkg::calc_t'(1));
	endfunction

	// zero or one means 16, odd is doubled
	function automatic logic [DW-1:0] eff_rounding(logic [RW-1:0] sr);
		logic [DW-1:0] r;
		if (sr <= RW'(1))
			r = bbcd_pkg::DEF_ROUNDING;
		else if (sr[0])
			r = {sr, 1'b0};
		else
			r = DW'(sr);
		return r;
	endfunction

	logic [2:0]          st_q;
	logic                out_valid_q;
	logic [SZW-1:0]      l_q, r_q, t_q, b_q;
	logic [DW-1:0]       rnd_q;
	bbcd_pkg::calc_t     x_q, y_q, cw_q, ch_q;
	bbcd_pkg::calc_t     x0, y0, cw0, ch0;
	bbcd_pkg::calc_t     sel, mag, rem_s, shrink, adj;
	bbcd_pkg::div_req_t  div_req;
	bbcd_pkg::div_rsp_t  div_rsp;
	logic                load;

	logic [BW-1:0]       left_q, right_q, top_q, bottom_q;
	logic signed [OW-1:0] crop_x_q, crop_y_q;
	logic signed [MW-1:0] crop_w_q, crop_h_q;

	assign x0  = floor_even(bbcd_pkg::calc_t'(l_q) + bbcd_pkg::calc_t'(1));
	assign y0  = floor_even(bbcd_pkg::calc_t'(t_q) + bbcd_pkg::calc_t'(1));
	assign cw0 = bbcd_pkg::calc_t'(r_q) - x0 + bbcd_pkg::calc_t'(1);
	assign ch0 = bbcd_pkg::calc_t'(b_q) - y0 + bbcd_pkg::calc_t'(1);

	// remainder carries the sign of the dividend
	assign sel    = (st_q == ST_DIV_H || st_q == ST_WAIT_H) ? ch_q : cw_q;
	assign mag    = sel[KW-1] ? -sel : sel;
	assign rem_s  = bbcd_pkg::calc_t'(div_rsp.rem);
	assign shrink = sel[KW-1] ? -rem_s : rem_s;
	assign adj    = center_adj(shrink);

	assign div_req.start    = (st_q == ST_DIV_W) || (st_q == ST_DIV_H);
	assign div_req.dividend = NW'(mag);
	assign div_req.divisor  = rnd_q;

	bbcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign load = (st_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE:   if (req.start) st_q <= ST_PREP;
				ST_PREP:   st_q <= ST_DIV_W;
				ST_DIV_W:  st_q <= ST_WAIT_W;
				ST_WAIT_W: if (div_rsp.done) st_q <= ST_DIV_H;
				ST_DIV_H:  st_q <= ST_WAIT_H;
				ST_WAIT_H: if (div_rsp.done) st_q <= ST_HOLD;
				ST_HOLD:   if (load) st_q <= ST_IDLE;
				default:   st_q <= ST_IDLE;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && req.start) begin
			l_q   <= req.left;
			r_q   <= req.right;
			t_q   <= req.top;
			b_q   <= req.bottom;
			rnd_q <= eff_rounding(req.rounding);
		end
		if (st_q == ST_PREP) begin
			x_q  <= x0;
			y_q  <= y0;
			cw_q <= cw0;
			ch_q <= ch0;
		end
		if (st_q == ST_WAIT_W && div_rsp.done) begin
			cw_q <= cw_q - shrink;
			x_q  <= x_q + adj;
		end
		if (st_q == ST_WAIT_H && div_rsp.done) begin
			ch_q <= ch_q - shrink;
			y_q  <= y_q + adj;
		end
		if (load) begin
			left_q   <= BW'(l_q);
			right_q  <= BW'(r_q);
			top_q    <= BW'(t_q);
			bottom_q <= BW'(b_q);
			crop_x_q <= OW'(x_q);
			crop_y_q <= OW'(y_q);
			crop_w_q <= MW'(cw_q);
			crop_h_q <= MW'(ch_q);
		end
	end

	assign idle         = (st_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign left_bound   = left_q;
	assign right_bound  = right_q;
	assign top_bound    = top_q;
	assign bottom_bound = bottom_q;
	assign crop_x       = crop_x_q;
	assign crop_y       = crop_y_q;
	assign crop_w       = crop_w_q;
	assign crop_h       = crop_h_q;

endmodule

// ===== design/black_border_crop_detector_core.sv =====
// ----------------------------------------------------------------------------
// black_border_crop_detector_core
// Column and row luma sums over raster frames, sticky content bounds and a
// crop rectangle after the last pixel of every active frame.
// ----------------------------------------------------------------------------
//  channel  | signals                             | transfer when
//  ---------+-------------------------------------+------------------------
//  input    | in_valid, in_ready, pixel           | in_valid & in_ready
//  output   | out_valid, out_ready, bounds, crop  | out_valid & out_ready
//  config   | cfg_we, cfg_index, cfg_data         | cfg_we
//
//  one pixel per clock unless stalled; column sums live in a one-port-write,
//  one-port-read memory, read at transfer and written back in the next cycle,
//  with a bypass when the same column comes up again (one-pixel-wide frames)
//  the last pixel of a frame waits while the crop unit is busy; the unit runs
//  two 13-step remainder runs per frame and is held by output stalls
//  no clearing pass after reset: the first row of a frame overwrites the sums
//  in_ready drops during a configuration write
// ----------------------------------------------------------------------------
module black_border_crop_detector_core #(
	parameter int MAX_WIDTH  = bbcd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bbcd_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [bbcd_pkg::PIX_W-1:0]     pixel,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [bbcd_pkg::BOUND_W-1:0]   left_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   right_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   top_bound,
	output logic        [bbcd_pkg::BOUND_W-1:0]   bottom_bound,
	output logic signed [bbcd_pkg::ORG_W-1:0]     crop_x,
	output logic signed [bbcd_pkg::ORG_W-1:0]     crop_y,
	output logic signed [bbcd_pkg::DIM_W-1:0]     crop_w,
	output logic signed [bbcd_pkg::DIM_W-1:0]     crop_h,
	input  logic                                  cfg_we,
	input  logic        [bbcd_pkg::IDX_W-1:0]     cfg_index,
	input  logic        [bbcd_pkg::CFG_W-1:0]     cfg_data
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SW  = RW + bbcd_pkg::PIX_W;
	localparam int RSW = CW + bbcd_pkg::PIX_W;
	localparam int CTW = RW + bbcd_pkg::PIX_W + 1;
	localparam int RTW = CW + bbcd_pkg::PIX_W + 1;
	localparam int PW  = bbcd_pkg::PIX_W;
	localparam int LW  = bbcd_pkg::LIMIT_W;
	localparam int SZW = bbcd_pkg::SIZE_W;
	localparam int RST_W = (bbcd_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : bbcd_pkg::RST_FRAME_WIDTH;
	localparam int RST_H = (bbcd_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : bbcd_pkg::RST_FRAME_HEIGHT;

	// configuration and thresholds
	logic [CW:0]                     w_q, w_new;
	logic [RW:0]                     h_q, h_new;
	logic [CW-1:0]                   wm1_q, wm1_new;
	logic [RW-1:0]                   hm1_q, hm1_new;
	logic [LW-1:0]                   limit_q;
	logic [bbcd_pkg::ROUND_W-1:0]    rounding_q;
	logic [LW:0]                     lim1;
	logic [CTW-1:0]                  col_thr_q;
	logic [RTW-1:0]                  row_thr_q;

	// position and bounds
	logic [CW-1:0]   col_q, left_q, right_q, left_d, right_d;
	logic [RW-1:0]   row_q, top_q, bottom_q, top_d, bottom_d;
	logic [1:0]      frames_q;
	logic [RSW-1:0]  row_sum_q, row_total;
	logic            last_col, last_row, last_px, acc;

	// pipeline stage
	logic            valid_s1, fwd_s1, first_row_s1, last_row_s1, last_col_s1;
	logic [PW-1:0]   px_s1;
	logic [CW-1:0]   col_s1;
	logic [RW-1:0]   row_s1;
	logic [SW-1:0]   fwd_data_s1, colsum_rd_s1, colsum_base, colsum_new;
	logic            active, col_hit, row_hit, frame_end_s1, crop_start, crop_idle;

	logic [SW-1:0]   colsum_mem [MAX_WIDTH];

	bbcd_pkg::crop_req_t crop_req;

	// zero acts as one, oversize clips to the maximum
	always_comb begin
		if (cfg_data == '0)
			w_new = (CW + 1)'(1);
		else if (int'(cfg_data) > MAX_WIDTH)
			w_new = (CW + 1)'(MAX_WIDTH);
		else
			w_new = (CW + 1)'(cfg_data);
		if (cfg_data == '0)
			h_new = (RW + 1)'(1);
		else if (int'(cfg_data) > MAX_HEIGHT)
			h_new = (RW + 1)'(MAX_HEIGHT);
		else
			h_new = (RW + 1)'(cfg_data);
	end
	assign wm1_new = CW'(w_new - (CW + 1)'(1));
	assign hm1_new = RW'(h_new - (RW + 1)'(1));

	assign last_col = (col_q == wm1_q);
	assign last_row = (row_q == hm1_q);
	assign last_px  = last_col & last_row;

	// floor(sum / n) > limit  <=>  sum >= (limit + 1) * n
	assign lim1 = {1'b0, limit_q} + (LW + 1)'(1);

	assign active       = frames_q[1];
	assign colsum_base  = fwd_s1 ? fwd_data_s1 : colsum_rd_s1;
	assign colsum_new   = first_row_s1 ? SW'(px_s1) : colsum_base + SW'(px_s1);
	assign row_total    = row_sum_q + RSW'(px_s1);
	assign col_hit      = valid_s1 & active & last_row_s1 & (CTW'(colsum_new) >= col_thr_q);
	assign row_hit      = valid_s1 & active & last_col_s1 & (RTW'(row_total) >= row_thr_q);
	assign left_d       = (col_hit && col_s1 < left_q) ? col_s1 : left_q;
	assign right_d      = (col_hit && col_s1 > right_q) ? col_s1 : right_q;
	assign top_d        = (row_hit && row_s1 < top_q) ? row_s1 : top_q;
	assign bottom_d     = (row_hit && row_s1 > bottom_q) ? row_s1 : bottom_q;
	assign frame_end_s1 = valid_s1 & last_col_s1 & last_row_s1;
	assign crop_start   = frame_end_s1 & active;

	// only the frame's last pixel waits for the crop unit
	assign in_ready = !cfg_we && !(last_px && (!crop_idle || crop_start));
	assign acc      = in_valid & in_ready;

	assign crop_req.start    = crop_start;
	assign crop_req.left     = SZW'(left_d);
	assign crop_req.right    = SZW'(right_d);
	assign crop_req.top      = SZW'(top_d);
	assign crop_req.bottom   = SZW'(bottom_d);
	assign crop_req.rounding = rounding_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= (CW + 1)'(RST_W);
			wm1_q      <= CW'(RST_W - 1);
			h_q        <= (RW + 1)'(RST_H);
			hm1_q      <= RW'(RST_H - 1);
			limit_q    <= bbcd_pkg::RST_BLACK_LIMIT;
			rounding_q <= bbcd_pkg::RST_SIZE_ROUNDING;
			col_q      <= '0;
			row_q      <= '0;
			frames_q   <= '0;
			left_q     <= CW'(RST_W - 1);
			right_q    <= '0;
			top_q      <= RW'(RST_H - 1);
			bottom_q   <= '0;
			row_sum_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= acc;
			if (acc) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (valid_s1) begin
				row_sum_q <= last_col_s1 ? '0 : row_total;
				left_q    <= left_d;
				right_q   <= right_d;
				top_q     <= top_d;
				bottom_q  <= bottom_d;
				if (frame_end_s1 && frames_q != 2'd3)
					frames_q <= frames_q + 2'd1;
			end
			// a size write restarts detection
			if (cfg_we) begin
				unique case (cfg_index)
					bbcd_pkg::REG_FRAME_WIDTH: begin
						w_q       <= w_new;
						wm1_q     <= wm1_new;
						left_q    <= wm1_new;
						top_q     <= hm1_q;
						right_q   <= '0;
						bottom_q  <= '0;
						frames_q  <= '0;
						row_sum_q <= '0;
						col_q     <= '0;
						row_q     <= '0;
					end
					bbcd_pkg::REG_FRAME_HEIGHT: begin
						h_q       <= h_new;
						hm1_q     <= hm1_new;
						left_q    <= wm1_q;
						top_q     <= hm1_new;
						right_q   <= '0;
						bottom_q  <= '0;
						frames_q  <= '0;
						row_sum_q <= '0;
						col_q     <= '0;
						row_q     <= '0;
					end
					bbcd_pkg::REG_BLACK_LIMIT: begin
						limit_q <= cfg_data[LW-1:0];
					end
					bbcd_pkg::REG_SIZE_ROUNDING: begin
						rounding_q <= cfg_data[bbcd_pkg::ROUND_W-1:0];
					end
					default: begin
						limit_q <= limit_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		col_thr_q <= CTW'(CTW'(lim1) * CTW'(h_q));
		row_thr_q <= RTW'(RTW'(lim1) * RTW'(w_q));
		if (acc) begin
			px_s1        <= pixel;
			col_s1       <= col_q;
			row_s1       <= row_q;
			first_row_s1 <= (row_q == '0);
			last_row_s1  <= last_row;
			last_col_s1  <= last_col;
			// same column read while its sum is being written back
			fwd_s1       <= valid_s1 && (col_s1 == col_q);
			fwd_data_s1  <= colsum_new;
		end
	end

	// column sum memory: read at transfer, write back from the stage
	always_ff @(posedge clk) begin
		if (valid_s1)
			colsum_mem[col_s1] <= colsum_new;
		if (acc)
			colsum_rd_s1 <= colsum_mem[col_q];
	end

	bbcd_crop u_crop (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (crop_req),
		.idle         (crop_idle),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_bound   (left_bound),
		.right_bound  (right_bound),
		.top_bound    (top_bound),
		.bottom_bound (bottom_bound),
		.crop_x       (crop_x),
		.crop_y       (crop_y),
		.crop_w       (crop_w),
		.crop_h       (crop_h)
	);

endmodule

// ===== design/bbcd_checker.sv =====
// ----------------------------------------------------------------------------
// bbcd_checker
// Port-level checks on the crop detector, attached to every instance.
// ----------------------------------------------------------------------------
module bbcd_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic        [bbcd_pkg::PIX_W-1:0]     pixel,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic        [bbcd_pkg::BOUND_W-1:0]   left_bound,
	input logic        [bbcd_pkg::BOUND_W-1:0]   right_bound,
	input logic        [bbcd_pkg::BOUND_W-1:0]   top_bound,
	input logic        [bbcd_pkg::BOUND_W-1:0]   bottom_bound,
	input logic signed [bbcd_pkg::ORG_W-1:0]     crop_x,
	input logic signed [bbcd_pkg::ORG_W-1:0]     crop_y,
	input logic signed [bbcd_pkg::DIM_W-1:0]     crop_w,
	input logic signed [bbcd_pkg::DIM_W-1:0]     crop_h,
	input logic                                  cfg_we,
	input logic        [bbcd_pkg::IDX_W-1:0]     cfg_index,
	input logic        [bbcd_pkg::CFG_W-1:0]     cfg_data
);

	// no pixel transfer together with a register write
	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !in_ready)
		else $error("pixel transfer during configuration write");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(crop_x) && $stable(crop_y)
			&& $stable(crop_w) && $stable(crop_h) && $stable(left_bound)
			&& $stable(right_bound) && $stable(top_bound) && $stable(bottom_bound))
		else $error("result changed while stalled");

	// origin is even-rounded and the size is a multiple of an even rounding
	a_crop_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !crop_x[0] && !crop_y[0] && !crop_w[0] && !crop_h[0])
		else $error("crop rectangle not even");

endmodule

bind black_border_crop_detector_core bbcd_checker u_bbcd_checker (.*);

// ===== verif/tb_black_border_crop_detector_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_black_border_crop_detector_core
// Self-checking bench for the black border crop detector. A short table of
// directed frames comes first: reset settings, a limit change in mid-frame,
// zero sizes and one-pixel frames. Random phases follow. Each phase may set new
// sizes, a new limit and a new rounding, then sends frames with a bright area
// on a dark border, all-dark, bright and noise frames, and sometimes a frame
// that is cut off. Two phases at the largest sizes close the run. Every pixel
// transfer goes through a bound and crop tracker in the bench. Every result
// transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_black_border_crop_detector_core;
	import bbcd_pkg::*;

	localparam int SETTLE_CYC  = 64;    // crop unit plus pipeline
	localparam int STALL_LIMIT = 4000;
	localparam int RAND_PIXELS = 1400;
	localparam int RAND_CROPS  = 48;
	localparam int REPORT_CAP  = 40;

	typedef struct packed {
		logic        [BOUND_W-1:0] left;
		logic        [BOUND_W-1:0] right;
		logic        [BOUND_W-1:0] top;
		logic        [BOUND_W-1:0] bottom;
		logic signed [ORG_W-1:0]   crop_x;
		logic signed [ORG_W-1:0]   crop_y;
		logic signed [DIM_W-1:0]   crop_w;
		logic signed [DIM_W-1:0]   crop_h;
	} crop_res_t;

	typedef enum logic {STEP_CFG, STEP_PIX} step_kind_e;

	typedef struct {
		step_kind_e        kind;
		logic [IDX_W-1:0]  index;
		logic [CFG_W-1:0]  data;
		logic [PIX_W-1:0]  value;
		bit                typed;
		crop_res_t         crop;
	} step_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic        [PIX_W-1:0]   pixel     = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic        [BOUND_W-1:0] left_bound;
	logic        [BOUND_W-1:0] right_bound;
	logic        [BOUND_W-1:0] top_bound;
	logic        [BOUND_W-1:0] bottom_bound;
	logic signed [ORG_W-1:0]   crop_x;
	logic signed [ORG_W-1:0]   crop_y;
	logic signed [DIM_W-1:0]   crop_w;
	logic signed [DIM_W-1:0]   crop_h;
	logic                      cfg_we    = 1'b0;
	logic        [IDX_W-1:0]   cfg_index = '0;
	logic        [CFG_W-1:0]   cfg_data  = '0;

	black_border_crop_detector_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel        (pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_bound   (left_bound),
		.right_bound  (right_bound),
		.top_bound    (top_bound),
		.bottom_bound (bottom_bound),
		.crop_x       (crop_x),
		.crop_y       (crop_y),
		.crop_w       (crop_w),
		.crop_h       (crop_h),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// tracker state: settings as the block sees them and the frame scan
	logic [SIZE_W-1:0]  size_w;
	logic [SIZE_W-1:0]  size_h;
	logic [LIMIT_W-1:0] limit_now;
	logic [ROUND_W-1:0] round_now;
	int                 col_acc [DEF_MAX_WIDTH];
	int                 row_acc;
	int                 col_at;
	int                 row_at;
	int                 frames_in;
	int                 edge_l;
	int                 edge_r;
	int                 edge_t;
	int                 edge_b;

	crop_res_t crop_due [$];
	step_t     plan [$];
	int        sent_px     = 0;
	int        crops_made  = 0;
	int        mismatches  = 0;
	int        tx_idle     = 27;
	int        rx_idle     = 78;
	int        quiet       = 0;
	crop_res_t seen;
	crop_res_t want;

	function automatic int eff_dim(input logic [SIZE_W-1:0] v, input int cap);
		if (v == '0)
			return 1;
		return (int'(v) > cap) ? cap : int'(v);
	endfunction

	function automatic int even_floor(input int v);
		return v - (v & 1);
	endfunction

	task automatic clear_tracking();
		edge_l    = eff_dim(size_w, DEF_MAX_WIDTH) - 1;
		edge_t    = eff_dim(size_h, DEF_MAX_HEIGHT) - 1;
		edge_r    = 0;
		edge_b    = 0;
		frames_in = 0;
		row_acc   = 0;
		col_at    = 0;
		row_at    = 0;
	endtask

	task automatic track_pixel(input logic [PIX_W-1:0] px, output bit hit,
			output crop_res_t res);
		int w;
		int h;
		int c;
		int r;
		int rnd;
		int x;
		int y;
		int cw;
		int ch;
		int cut;
		bit live;
		bit row_done;
		bit frame_done;
		w    = eff_dim(size_w, DEF_MAX_WIDTH);
		h    = eff_dim(size_h, DEF_MAX_HEIGHT);
		live = frames_in >= 2;
		c    = (col_at >= w) ? w - 1 : col_at;
		r    = (row_at >= h) ? h - 1 : row_at;
		hit  = 1'b0;
		res  = '0;

		col_acc[c] = (r == 0) ? int'(px) : col_acc[c] + int'(px);
		row_acc    = row_acc + int'(px);
		if (live && r == h - 1 && col_acc[c] / h > int'(limit_now)) begin
			if (c < edge_l)
				edge_l = c;
			if (c > edge_r)
				edge_r = c;
		end

		row_done   = (c == w - 1);
		frame_done = row_done && (r == h - 1);
		if (row_done) begin
			if (live && row_acc / w > int'(limit_now)) begin
				if (r < edge_t)
					edge_t = r;
				if (r > edge_b)
					edge_b = r;
			end
			row_acc = 0;
			col_at  = 0;
			row_at  = frame_done ? 0 : r + 1;
		end else begin
			col_at = c + 1;
			row_at = r;
		end

		if (!frame_done)
			return;
		if (frames_in < 3)
			frames_in++;
		if (!live)
			return;

		rnd = int'(round_now);
		if (rnd <= 1)
			rnd = 16;
		if (rnd % 2 != 0)
			rnd = rnd * 2;
		x  = even_floor(edge_l + 1);
		y  = even_floor(edge_t + 1);
		cw = edge_r - x + 1;
		ch = edge_b - y + 1;
		// truncating remainder, so an empty crop keeps a negative size
		cut = cw % rnd;
		cw  = cw - cut;
		x   = x + even_floor(cut / 2 + 1);
		cut = ch % rnd;
		ch  = ch - cut;
		y   = y + even_floor(cut / 2 + 1);

		hit        = 1'b1;
		res.left   = BOUND_W'(edge_l);
		res.right  = BOUND_W'(edge_r);
		res.top    = BOUND_W'(edge_t);
		res.bottom = BOUND_W'(edge_b);
		res.crop_x = ORG_W'(x);
		res.crop_y = ORG_W'(y);
		res.crop_w = DIM_W'(cw);
		res.crop_h = DIM_W'(ch);
	endtask

	task automatic flag_mismatch(input string what, input int got, input int exp_val);
		if (mismatches < REPORT_CAP)
			$display("%0t: %s got %0d, want %0d", $time, what, got, exp_val);
		mismatches++;
	endtask

	task automatic push_pixel(input logic [PIX_W-1:0] v, input bit typed,
			input crop_res_t typed_crop);
		bit        hit;
		crop_res_t res;
		@(negedge clk);
		if ($urandom_range(99, 0) < tx_idle) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99, 0) < tx_idle);
		end
		in_valid <= 1'b1;
		pixel    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_px++;
		track_pixel(v, hit, res);
		if (hit) begin
			crop_due.push_back(typed ? typed_crop : res);
			crops_made++;
		end
	endtask

	// drop valid, drain pending crops, then let a frame that ended without
	// a result clear the crop unit
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (crop_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		in_valid  <= 1'b0;
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH: begin
				size_w = data[SIZE_W-1:0];
				clear_tracking();
			end
			REG_FRAME_HEIGHT: begin
				size_h = data[SIZE_W-1:0];
				clear_tracking();
			end
			REG_BLACK_LIMIT:   limit_now = data[LIMIT_W-1:0];
			REG_SIZE_ROUNDING: round_now = data[ROUND_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic feed_frame(input int count);
		int               w;
		int               h;
		int               style;
		int               x0;
		int               x1;
		int               y0;
		int               y1;
		int               cx;
		int               cy;
		logic [PIX_W-1:0] v;
		w     = eff_dim(size_w, DEF_MAX_WIDTH);
		h     = eff_dim(size_h, DEF_MAX_HEIGHT);
		style = int'($urandom_range(99, 0));
		x0    = int'($urandom_range(w - 1, 0));
		x1    = int'($urandom_range(w - 1, x0));
		y0    = int'($urandom_range(h - 1, 0));
		y1    = int'($urandom_range(h - 1, y0));
		for (int n = 0; n < count; n++) begin
			cx = n % w;
			cy = n / w;
			if (style < 15)
				v = PIX_W'($urandom_range(12, 0));
			else if (style < 27)
				v = PIX_W'($urandom_range(255, 0));
			else if (style < 33)
				v = PIX_W'($urandom_range(255, 200));
			else if (cx >= x0 && cx <= x1 && cy >= y0 && cy <= y1)
				v = PIX_W'($urandom_range(255, 64));
			else
				v = PIX_W'($urandom_range(20, 0));
			push_pixel(v, 1'b0, '0);
		end
	endtask

	task automatic play_phase(input bit fixed, input logic [CFG_W-1:0] wd,
			input logic [CFG_W-1:0] hd, input int frames);
		int                 k;
		int                 area;
		logic [LIMIT_W-1:0] lim;
		logic [ROUND_W-1:0] rnd;
		if (sent_px < 700) begin
			tx_idle = 27;
			rx_idle = 78;
		end else if (sent_px < 1400) begin
			tx_idle = 78;
			rx_idle = 27;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
		settle();
		if (fixed || $urandom_range(99, 0) < 80) begin
			if (!fixed) begin
				k = int'($urandom_range(99, 0));
				if (k < 10)
					wd = '0;
				else if (k < 70)
					wd = CFG_W'($urandom_range(8, 1));
				else if (k < 95)
					wd = CFG_W'($urandom_range(24, 9));
				else
					wd = CFG_W'($urandom_range(48, 25));
				hd = ($urandom_range(9, 0) == 0) ? '0 : CFG_W'($urandom_range(8, 1));
			end
			cfg_write(REG_FRAME_WIDTH, wd);
			cfg_write(REG_FRAME_HEIGHT, hd);
		end
		if ($urandom_range(99, 0) < 70) begin
			k = int'($urandom_range(99, 0));
			if (k < 10)
				lim = '0;
			else if (k < 20)
				lim = '1;
			else
				lim = LIMIT_W'($urandom_range(90, 0));
			cfg_write(REG_BLACK_LIMIT, {4'($urandom_range(15, 0)), lim});
		end
		if ($urandom_range(99, 0) < 70) begin
			k = int'($urandom_range(99, 0));
			if (k < 20)
				rnd = '0;
			else if (k < 30)
				rnd = ROUND_W'(1);
			else if (k < 50)
				rnd = ROUND_W'($urandom_range(4, 2));
			else if (k < 75)
				rnd = ROUND_W'($urandom_range(32, 5));
			else if (k < 88)
				rnd = ROUND_W'($urandom_range(2047, 1024));
			else
				rnd = ROUND_W'($urandom_range(2047, 0));
			cfg_write(REG_SIZE_ROUNDING, {1'($urandom_range(1, 0)), rnd});
		end
		area = eff_dim(size_w, DEF_MAX_WIDTH) * eff_dim(size_h, DEF_MAX_HEIGHT);
		repeat (frames)
			feed_frame(area);
		// a cut-off frame leaves the scan mid-frame for the next phase
		if (!fixed && $urandom_range(99, 0) < 20)
			feed_frame(int'($urandom_range(area, 1)));
	endtask

	function automatic step_t cfg_step(input logic [IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		step_t s;
		s = '{STEP_CFG, idx, data, '0, 1'b0, '0};
		return s;
	endfunction

	function automatic step_t pix_step(input logic [PIX_W-1:0] v, input bit typed);
		step_t s;
		s = '{STEP_PIX, '0, '0, v, typed, '0};
		return s;
	endfunction

	always @(negedge clk)
		out_ready <= ($urandom_range(99, 0) >= rx_idle);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = '{left_bound, right_bound, top_bound, bottom_bound,
				crop_x, crop_y, crop_w, crop_h};
			if (crop_due.size() == 0) begin
				flag_mismatch("result transfer with nothing pending", 1, 0);
			end else begin
				want = crop_due.pop_front();
				if (seen.left != want.left)
					flag_mismatch("left_bound", seen.left, want.left);
				if (seen.right != want.right)
					flag_mismatch("right_bound", seen.right, want.right);
				if (seen.top != want.top)
					flag_mismatch("top_bound", seen.top, want.top);
				if (seen.bottom != want.bottom)
					flag_mismatch("bottom_bound", seen.bottom, want.bottom);
				if (seen.crop_x != want.crop_x)
					flag_mismatch("crop_x", seen.crop_x, want.crop_x);
				if (seen.crop_y != want.crop_y)
					flag_mismatch("crop_y", seen.crop_y, want.crop_y);
				if (seen.crop_w != want.crop_w)
					flag_mismatch("crop_w", seen.crop_w, want.crop_w);
				if (seen.crop_h != want.crop_h)
					flag_mismatch("crop_h", seen.crop_h, want.crop_h);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet == STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : stimulus
		int px0;
		int crops0;
		size_w    = SIZE_W'(RST_FRAME_WIDTH);
		size_h    = SIZE_W'(RST_FRAME_HEIGHT);
		limit_now = RST_BLACK_LIMIT;
		round_now = RST_SIZE_ROUNDING;
		clear_tracking();

		// typed rows expect an all-zero crop: a one-pixel frame trims its only pixel away
		plan = '{
			cfg_step(REG_FRAME_WIDTH, 12'd2),
			cfg_step(REG_FRAME_HEIGHT, 12'd2),
			// two warm-up frames, no result
			pix_step(8'd255, 1'b0), pix_step(8'd0, 1'b0),
			pix_step(8'd255, 1'b0), pix_step(8'd0, 1'b0),
			pix_step(8'd0, 1'b0), pix_step(8'd128, 1'b0),
			pix_step(8'd255, 1'b0), pix_step(8'd1, 1'b0),
			// first active frame under the reset limit and rounding
			pix_step(8'd30, 1'b0), pix_step(8'd20, 1'b0),
			pix_step(8'd0, 1'b0), pix_step(8'd40, 1'b0),
			// full-scale limit written mid-frame, scan position kept
			pix_step(8'd0, 1'b0), pix_step(8'd255, 1'b0),
			cfg_step(REG_BLACK_LIMIT, 12'hFFF),
			pix_step(8'd255, 1'b0), pix_step(8'd255, 1'b0),
			// zero sizes act as one pixel
			cfg_step(REG_FRAME_WIDTH, 12'd0),
			cfg_step(REG_FRAME_HEIGHT, 12'd0),
			pix_step(8'd255, 1'b0), pix_step(8'd0, 1'b0),
			pix_step(8'd255, 1'b1),
			cfg_step(REG_SIZE_ROUNDING, 12'd1),
			pix_step(8'd0, 1'b1),
			cfg_step(REG_SIZE_ROUNDING, 12'hFFF),
			pix_step(8'd128, 1'b1)
		};

		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				settle();
				cfg_write(plan[i].index, plan[i].data);
			end else begin
				push_pixel(plan[i].value, plan[i].typed, plan[i].crop);
			end
		end

		px0    = sent_px;
		crops0 = crops_made;
		while (sent_px - px0 < RAND_PIXELS || crops_made - crops0 < RAND_CROPS)
			play_phase(1'b0, '0, '0, int'($urandom_range(8, 3)));

		// oversized width clamps to the maximum, then the tallest frame
		play_phase(1'b1, 12'hFFF, 12'd0, 3);
		play_phase(1'b1, 12'd1, 12'd2048, 3);

		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
